// File: rtl/p2td_pkg.sv
// package for the planar 2bpp tile row decoder
// holds configuration, result types and register index codes; no dependencies
`timescale 1ns / 1ps

package p2td_pkg;

   localparam int NUM_LANES = 8;

   localparam logic [1:0] FMT_RGB24  = 2'd0;
   localparam logic [1:0] FMT_RGBA32 = 2'd1;
   localparam logic [1:0] FMT_RGBA16 = 2'd2;

   typedef enum logic [2:0] {
      REG_OUTPUT_FORMAT = 3'd0,
      REG_PALETTE_0     = 3'd1,
      REG_PALETTE_1     = 3'd2,
      REG_PALETTE_2     = 3'd3,
      REG_PALETTE_3     = 3'd4,
      REG_WIDTH_TILES   = 3'd5,
      REG_HEIGHT_TILES  = 3'd6,
      REG_TILE_ORDER    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]       output_format;
      logic [3:0][23:0] palette;
      logic [7:0]       width_tiles;
      logic [7:0]       height_tiles;
      logic             tile_order;
   } cfg_type;

   typedef struct packed {
      logic [23:0] row_address;
      logic        sprite_done;
   } addr_info_type;

   typedef struct packed {
      logic [23:0]                 row_address;
      logic [NUM_LANES-1:0][31:0]  color;
      logic                        sprite_done;
   } rsp_type;

endpackage

// File: rtl/p2td_lane.sv
// one pixel lane: picks the bit pair for its position and packs the palette colour
// depends on p2td_pkg
`timescale 1ns / 1ps

module p2td_lane (
   input  logic [2:0]        lane_idx,
   input  logic [7:0]        low_plane,
   input  logic [7:0]        high_plane,
   input  logic              mirror,
   input  p2td_pkg::cfg_type cfg,
   output logic [31:0]       color
);
   import p2td_pkg::*;

   logic [2:0]  bit_sel;
   logic [1:0]  pal_idx;
   logic [23:0] pal_val;

   always_comb begin
      bit_sel = mirror ? lane_idx : 3'd7 - lane_idx;
      pal_idx = {high_plane[bit_sel], low_plane[bit_sel]};
      pal_val = cfg.palette[pal_idx];
      unique case (cfg.output_format)
         FMT_RGBA32: color = {8'hFF, pal_val};
         FMT_RGBA16: color = {16'h0000, pal_val[15:0]};
         default:    color = {8'h00, pal_val};
      endcase
   end

endmodule

// File: rtl/p2td_addr_gen.sv
// tile position counters, row byte address and end of sprite flag
// depends on p2td_pkg
`timescale 1ns / 1ps

module p2td_addr_gen (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  p2td_pkg::cfg_type       cfg,
   output p2td_pkg::addr_info_type info
);
   import p2td_pkg::*;

   logic [7:0]  tile_col_ff, tile_col_in;
   logic [7:0]  tile_row_ff, tile_row_in;
   logic [2:0]  row_in_tile_ff, row_in_tile_in;
   logic [7:0]  w_eff, h_eff;
   logic [10:0] y_pos;
   logic [18:0] y_times_w;
   logic [22:0] lin;
   logic [24:0] scaled;
   logic        col_last, row_last, tile_end;

   always_comb begin
      w_eff     = (cfg.width_tiles == 8'd0) ? 8'd1 : cfg.width_tiles;
      h_eff     = (cfg.height_tiles == 8'd0) ? 8'd1 : cfg.height_tiles;
      y_pos     = {tile_row_ff, row_in_tile_ff};
      y_times_w = {8'd0, y_pos} * {11'd0, w_eff};
      lin       = {1'b0, y_times_w, 3'b000} + {12'd0, tile_col_ff, 3'b000};
      unique case (cfg.output_format)
         FMT_RGBA32: scaled = {lin, 2'b00};
         FMT_RGBA16: scaled = {1'b0, lin, 1'b0};
         default:    scaled = {1'b0, lin, 1'b0} + {2'b00, lin};
      endcase
      col_last = ({1'b0, tile_col_ff} + 9'd1) >= {1'b0, w_eff};
      row_last = ({1'b0, tile_row_ff} + 9'd1) >= {1'b0, h_eff};
      tile_end = (row_in_tile_ff == 3'd7);
      info.row_address = scaled[23:0];
      info.sprite_done = tile_end && col_last && row_last;
   end

   always_comb begin
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      row_in_tile_in = row_in_tile_ff + 3'd1;
      if (tile_end) begin
         if (!cfg.tile_order) begin
            if (col_last) begin
               tile_col_in = 8'd0;
               tile_row_in = row_last ? 8'd0 : tile_row_ff + 8'd1;
            end else begin
               tile_col_in = tile_col_ff + 8'd1;
            end
         end else begin
            if (row_last) begin
               tile_row_in = 8'd0;
               tile_col_in = col_last ? 8'd0 : tile_col_ff + 8'd1;
            end else begin
               tile_row_in = tile_row_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_col_ff    <= 8'd0;
         tile_row_ff    <= 8'd0;
         row_in_tile_ff <= 3'd0;
      end else if (advance) begin
         tile_col_ff    <= tile_col_in;
         tile_row_ff    <= tile_row_in;
         row_in_tile_ff <= row_in_tile_in;
      end
   end

   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      (advance && info.sprite_done) |=>
         (tile_col_ff == 8'd0 && tile_row_ff == 8'd0 && row_in_tile_ff == 3'd0))
      else $error("counters did not wrap after final row");

   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && !tile_end) |=>
         (row_in_tile_ff == $past(row_in_tile_ff) + 3'd1 && $stable(tile_col_ff)
          && $stable(tile_row_ff)))
      else $error("row step disturbed tile position");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(tile_col_ff) && $stable(tile_row_ff) && $stable(row_in_tile_ff)))
      else $error("counters moved without an item");

endmodule

// File: rtl/p2td_row_buffer.sv
// merge stage: gathers lane colours, address and flag into a two entry skid buffer
// depends on p2td_pkg
`timescale 1ns / 1ps

module p2td_row_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  p2td_pkg::rsp_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              out_valid,
   output p2td_pkg::rsp_type out_data
);
   import p2td_pkg::*;

   rsp_type    entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("buffer occupancy out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff ^ rd_ptr_ff) == (count_ff == 2'd1))
      else $error("buffer pointers disagree with occupancy");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("item lost on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("item repeated on pop");

endmodule

// File: rtl/planar_2bpp_tile_decoder_core.sv
// top level of the planar 2bpp tile row decoder
// eight pixel lanes, address counters and a two entry result buffer; uses p2td_pkg
// each accepted item's result is registered into the buffer and is shown from the buffer head
// throughput: one item per cycle while req_stall is low; the two entry buffer takes new items while one waits
// req_stall rises only when both buffer entries hold results not yet taken
// synchronous reset clears the tile counters, empties the buffer and loads register defaults
`timescale 1ns / 1ps

module planar_2bpp_tile_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_low_plane,
   input  logic [7:0]  req_high_plane,
   input  logic        req_mirror,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_row_address,
   output logic [31:0] rsp_color_0,
   output logic [31:0] rsp_color_1,
   output logic [31:0] rsp_color_2,
   output logic [31:0] rsp_color_3,
   output logic [31:0] rsp_color_4,
   output logic [31:0] rsp_color_5,
   output logic [31:0] rsp_color_6,
   output logic [31:0] rsp_color_7,
   output logic        rsp_sprite_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import p2td_pkg::*;

   cfg_type       cfg_ff;
   addr_info_type info;
   rsp_type       row_result, head;
   logic          accept, full;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_format <= FMT_RGB24;
         cfg_ff.palette       <= '0;
         cfg_ff.width_tiles   <= 8'd1;
         cfg_ff.height_tiles  <= 8'd1;
         cfg_ff.tile_order    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_OUTPUT_FORMAT: cfg_ff.output_format <= csr_data[1:0];
            REG_PALETTE_0:     cfg_ff.palette[0]    <= csr_data;
            REG_PALETTE_1:     cfg_ff.palette[1]    <= csr_data;
            REG_PALETTE_2:     cfg_ff.palette[2]    <= csr_data;
            REG_PALETTE_3:     cfg_ff.palette[3]    <= csr_data;
            REG_WIDTH_TILES:   cfg_ff.width_tiles   <= csr_data[7:0];
            REG_HEIGHT_TILES:  cfg_ff.height_tiles  <= csr_data[7:0];
            REG_TILE_ORDER:    cfg_ff.tile_order    <= csr_data[0];
            default: ;
         endcase
      end
   end

   p2td_addr_gen u_addr_gen (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg_ff),
      .info    (info)
   );

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      p2td_lane u_lane (
         .lane_idx   (3'(g)),
         .low_plane  (req_low_plane),
         .high_plane (req_high_plane),
         .mirror     (req_mirror),
         .cfg        (cfg_ff),
         .color      (row_result.color[g])
      );
   end

   assign row_result.row_address = info.row_address;
   assign row_result.sprite_done = info.sprite_done;

   p2td_row_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (row_result),
      .full      (full),
      .pop       (rsp_valid && !rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (head)
   );

   assign rsp_row_address = head.row_address;
   assign rsp_color_0     = head.color[0];
   assign rsp_color_1     = head.color[1];
   assign rsp_color_2     = head.color[2];
   assign rsp_color_3     = head.color[3];
   assign rsp_color_4     = head.color[4];
   assign rsp_color_5     = head.color[5];
   assign rsp_color_6     = head.color[6];
   assign rsp_color_7     = head.color[7];
   assign rsp_sprite_done = head.sprite_done;

endmodule
